FILE: rtl/core/aot_pkg.sv
package aot_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int PAGE_BYTES  = 4096;

  localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int VAL_W   = 34;
  localparam int REM_W   = $clog2(PAGE_BYTES);
  localparam int ENTRY_W = 64;

  localparam logic [1:0] REQ_RECORD  = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CHECK   = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_DENIED  = 3'd4;

endpackage

FILE: rtl/core/aot_ram.sv
module aot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/allocation_ownership_table.sv
// Allocation ownership table.
// Request channel: start/busy with in_req_type, in_address, in_length. A request
// is taken on a clock edge with start high and busy low; busy stays high while
// it is worked on.
// Result channel: out_valid strobes for one cycle with out_status and
// out_found_size. The receiver cannot stall it; the next request may be taken
// in the cycle the result is shown.
// Config channel: cfg_valid/cfg_ready writes cfg_kernel_task; ready while idle.
// Timing (N = slots): bad arguments and refused checks are answered in the
// cycle after they are taken; record tests one valid bit a cycle over up to
// N slots; release reads, then compares each of up to N slots from the table
// RAM. A check rounds its start down and its end up in the shared page
// rounding step, tests the walk once, then per page-walk step spends one slot
// scan, one rounding step and one more walk test.
// Reset: synchronous, active low; all slots free, kernel_task cleared. The
// table RAM holds no reset; per-slot valid bits mark live entries.
module allocation_ownership_table
  import aot_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_address,
  input  logic [31:0] in_length,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_kernel_task
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_REC     = 4'd1;
  localparam logic [3:0] S_RLS_RD  = 4'd2;
  localparam logic [3:0] S_RLS_CMP = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_LOOP    = 4'd5;
  localparam logic [3:0] S_CHK_RD  = 4'd6;
  localparam logic [3:0] S_CHK_CMP = 4'd7;

  localparam logic [1:0] D_PFLOOR = 2'd0;
  localparam logic [1:0] D_STOP   = 2'd1;
  localparam logic [1:0] D_PCEIL  = 2'd2;

  logic [3:0]             state_r, state_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic                   kernel_r;
  logic [31:0]            addr_r, addr_nxt;
  logic [31:0]            len_r, len_nxt;
  logic [VAL_W-1:0]       last_r, last_nxt;
  logic [VAL_W-1:0]       page_r, page_nxt;
  logic [VAL_W-1:0]       stop_r, stop_nxt;
  logic [VAL_W-1:0]       div_src_r, div_src_nxt;
  logic [1:0]             div_dst_r, div_dst_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_status_r, out_status_nxt;
  logic [31:0]            out_size_r, out_size_nxt;

  logic                   ram_we;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [32:0]            in_last;
  logic [31:0]            rd_base;
  logic [31:0]            rd_len;
  logic [VAL_W-1:0]       rd_end;
  logic                   hit;
  logic                   last_slot;
  logic [REM_W-1:0]       div_rem;
  logic [VAL_W-1:0]       div_floor;
  logic [VAL_W-1:0]       div_ceil;

  aot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({len_r, addr_r}),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = ~busy;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_size = out_size_r;

  assign in_last   = {1'b0, in_address} + {1'b0, in_length};
  assign rd_base   = ram_rdata[31:0];
  assign rd_len    = ram_rdata[63:32];
  assign rd_end    = VAL_W'(rd_base) + VAL_W'(rd_len);
  assign hit       = valid_r[slot_r] && (page_r >= VAL_W'(rd_base)) && (page_r < rd_end);
  assign last_slot = (slot_r == SLOT_W'(TABLE_SLOTS - 1));
  assign div_rem   = REM_W'(div_src_r % VAL_W'(PAGE_BYTES));
  assign div_floor = div_src_r - VAL_W'(div_rem);
  assign div_ceil  = (div_rem == '0) ? div_src_r : div_floor + VAL_W'(PAGE_BYTES);
  assign ram_we    = (state_r == S_REC) && !valid_r[slot_r];

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    valid_nxt      = valid_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    last_nxt       = last_r;
    page_nxt       = page_r;
    stop_nxt       = stop_r;
    div_src_nxt    = div_src_r;
    div_dst_nxt    = div_dst_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_size_nxt   = out_size_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          addr_nxt       = in_address;
          len_nxt        = in_length;
          last_nxt       = VAL_W'(in_last);
          slot_nxt       = '0;
          out_size_nxt   = '0;
          out_status_nxt = ST_BAD;
          case (in_req_type)
            REQ_RECORD: begin
              if (in_address == '0 || in_length == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_REC;
              end
            end
            REQ_RELEASE: begin
              if (in_address == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_RLS_RD;
              end
            end
            REQ_CHECK: begin
              if (in_address == '0 || in_length == '0) begin
                out_valid_nxt = 1'b1;
              end else if (kernel_r || (in_last[32] && in_last[31:0] != '0)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_DENIED;
              end else begin
                div_src_nxt = VAL_W'(in_address);
                div_dst_nxt = D_PFLOOR;
                state_nxt   = S_DIV;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_REC: begin
        if (!valid_r[slot_r]) begin
          valid_nxt[slot_r] = 1'b1;
          out_valid_nxt     = 1'b1;
          out_status_nxt    = ST_OK;
          state_nxt         = S_IDLE;
        end else if (last_slot) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_RLS_RD: begin
        state_nxt = S_RLS_CMP;
      end
      S_RLS_CMP: begin
        if (valid_r[slot_r] && rd_base == addr_r) begin
          valid_nxt[slot_r] = 1'b0;
          out_valid_nxt     = 1'b1;
          out_status_nxt    = ST_OK;
          out_size_nxt      = rd_len;
          state_nxt         = S_IDLE;
        end else if (last_slot) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MISSING;
          state_nxt      = S_IDLE;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_RLS_RD;
        end
      end
      S_DIV: begin
        case (div_dst_r)
          D_PFLOOR: begin
            page_nxt    = div_floor;
            div_src_nxt = last_r;
            div_dst_nxt = D_STOP;
          end
          D_STOP: begin
            stop_nxt  = div_ceil;
            state_nxt = S_LOOP;
          end
          default: begin
            page_nxt  = div_ceil;
            state_nxt = S_LOOP;
          end
        endcase
      end
      S_LOOP: begin
        if (page_r >= stop_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          slot_nxt  = '0;
          state_nxt = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        state_nxt = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (hit) begin
          div_src_nxt = rd_end;
          div_dst_nxt = D_PCEIL;
          state_nxt   = S_DIV;
        end else if (last_slot) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DENIED;
          state_nxt      = S_IDLE;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_CHK_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      kernel_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        kernel_r <= cfg_kernel_task;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    last_r       <= last_nxt;
    page_r       <= page_nxt;
    stop_r       <= stop_nxt;
    div_src_r    <= div_src_nxt;
    div_dst_r    <= div_dst_nxt;
    out_status_r <= out_status_nxt;
    out_size_r   <= out_size_nxt;
  end

endmodule

FILE: rtl/core/aot_checker.sv
module aot_checker
  import aot_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_req_type,
  input logic [31:0] in_address,
  input logic [31:0] in_length,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [31:0] out_found_size,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_kernel_task
);

  // unknown request code answers at once
  a_unknown_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type != REQ_RECORD && in_req_type != REQ_RELEASE &&
     in_req_type != REQ_CHECK) |=> (out_valid && out_status == ST_BAD))
    else $error("unknown request not refused");

  a_check_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_CHECK && (in_address == '0 || in_length == '0))
    |=> (out_valid && out_status == ST_BAD))
    else $error("zero-argument check not refused");

  // a request that ran over several cycles ends with its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_size_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_found_size == '0))
    else $error("size reported on a failed request");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_BAD || out_status == ST_FULL ||
                   out_status == ST_MISSING || out_status == ST_DENIED))
    else $error("status code out of range");

endmodule

bind allocation_ownership_table aot_checker u_aot_checker (.*);
